[design/first_fit_page_run_allocator_assert.svh]
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define FFPRA_ASSERT_SAME(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (prop)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define FFPRA_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

[design/ffpra_pkg.sv]
package ffpra_pkg;

    typedef enum logic [1:0] {
        PG_AVAIL    = 2'd0,
        PG_USED     = 2'd1,
        PG_RESERVED = 2'd2
    } t_page_state;

    localparam logic [2:0] ACT_ALLOC         = 3'd0;
    localparam logic [2:0] ACT_FREE          = 3'd1;
    localparam logic [2:0] ACT_MARK_USED     = 3'd2;
    localparam logic [2:0] ACT_MARK_RESERVED = 3'd3;
    localparam logic [2:0] ACT_CLEAR         = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NORUN   = 2'd2;

    localparam int unsigned PAGE_SPACE = 1048576;

endpackage

[design/ffpra_page_table.sv]
module ffpra_page_table
    import ffpra_pkg::*;
#(
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_page_state              i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_page_state              o_rdata
);

    t_page_state r_mem [DEPTH];
    t_page_state r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/first_fit_page_run_allocator.sv]
// First-fit page run allocator. A request is taken when start is high and busy is low, and
// exactly one result comes back later as a single-cycle o_done strobe with o_status and
// o_base_page; the receiver cannot stall it, so it must take the result in that cycle. A
// page counter walks the page table, a memory with one write port and one registered read
// port, one page per cycle; clear all walks it with a separate index, writing every page
// as available. An alloc scans pages for a free run and then writes the run as used; free
// and mark walk their region; a request rejected up front answers in the cycle after it
// is taken, without leaving idle. After reset the table is cleared in a pass with busy
// high. The pool base register takes a transfer only while busy and start are both low.
`include "first_fit_page_run_allocator_assert.svh"

module first_fit_page_run_allocator
    import ffpra_pkg::*;
#(
    parameter int unsigned TABLE_PAGES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [19:0] i_first_page,
    input  logic [20:0] i_end_page,
    input  logic [12:0] i_page_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_data,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [19:0] o_base_page
);

    localparam int unsigned IW = $clog2(TABLE_PAGES);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CLEAR  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_WRITE  = 5'b01000,
        S_MODIFY = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [19:0] r_pool_base;
    logic [IW-1:0] r_clr_idx, n_clr_idx;
    logic        r_clr_respond, n_clr_respond;
    logic [2:0]  r_action, n_action;
    logic [20:0] r_ptr, n_ptr;
    logic        r_eval_vld, n_eval_vld;
    logic [20:0] r_eval_page, n_eval_page;
    logic [20:0] r_end, n_end;
    logic [20:0] r_stop, n_stop;
    logic [20:0] r_lim, n_lim;
    logic [12:0] r_count, n_count;
    logic [12:0] r_run, n_run;
    logic [19:0] r_run_base, n_run_base;
    logic [12:0] r_left, n_left;
    logic        r_done, n_done;
    logic [1:0]  r_status, n_status;
    logic [19:0] r_base, n_base;

    logic [21:0] lim_sum;
    logic [20:0] lim_now;
    logic [20:0] free_end;
    logic [20:0] rd_off;
    logic [20:0] ev_off;
    logic        issue;

    logic        wr_en;
    logic [IW-1:0] wr_addr;
    t_page_state wr_data;
    t_page_state rd_data;

    assign lim_sum  = {2'b00, r_pool_base} + 22'(TABLE_PAGES);
    assign lim_now  = (lim_sum > 22'(PAGE_SPACE)) ? 21'(PAGE_SPACE) : lim_sum[20:0];
    assign free_end = {1'b0, i_first_page} + {8'b0, i_page_count};
    assign rd_off   = r_ptr - {1'b0, r_pool_base};
    assign ev_off   = r_eval_page - {1'b0, r_pool_base};
    assign issue    = (r_ptr < r_stop);

    ffpra_page_table #(
        .DEPTH (TABLE_PAGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_off[IW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state       = r_state;
        n_clr_idx     = r_clr_idx;
        n_clr_respond = r_clr_respond;
        n_action      = r_action;
        n_ptr         = r_ptr;
        n_eval_vld    = r_eval_vld;
        n_eval_page   = r_eval_page;
        n_end         = r_end;
        n_stop        = r_stop;
        n_lim         = r_lim;
        n_count       = r_count;
        n_run         = r_run;
        n_run_base    = r_run_base;
        n_left        = r_left;
        n_done        = 1'b0;
        n_status      = r_status;
        n_base        = r_base;
        wr_en         = 1'b0;
        wr_addr       = ev_off[IW-1:0];
        wr_data       = PG_AVAIL;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_action   = i_action;
                    n_ptr      = {1'b0, i_first_page};
                    n_eval_vld = 1'b0;
                    n_end      = i_end_page;
                    n_count    = i_page_count;
                    n_lim      = lim_now;
                    n_run      = '0;
                    n_status   = ST_INVALID;
                    n_base     = '0;
                    case (i_action)
                        ACT_CLEAR: begin
                            n_state       = S_CLEAR;
                            n_clr_idx     = '0;
                            n_clr_respond = 1'b1;
                        end
                        ACT_ALLOC: begin
                            if (i_first_page < r_pool_base || i_page_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ACT_FREE: begin
                            n_stop = free_end;
                            if (i_first_page < r_pool_base || free_end > lim_now) begin
                                n_done = 1'b1;
                            end else if (i_page_count == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_OK;
                            end else begin
                                n_state = S_MODIFY;
                            end
                        end
                        ACT_MARK_USED, ACT_MARK_RESERVED: begin
                            n_stop = i_end_page;
                            if (i_first_page < r_pool_base ||
                                (i_end_page > {1'b0, i_first_page} && i_end_page > lim_now)) begin
                                n_done = 1'b1;
                            end else if (i_end_page <= {1'b0, i_first_page}) begin
                                n_done   = 1'b1;
                                n_status = ST_OK;
                            end else begin
                                n_state = S_MODIFY;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                wr_en     = 1'b1;
                wr_addr   = r_clr_idx;
                wr_data   = PG_AVAIL;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IW'(TABLE_PAGES - 1)) begin
                    n_state       = S_IDLE;
                    n_clr_respond = 1'b0;
                    n_done        = r_clr_respond;
                    n_status      = ST_OK;
                    n_base        = '0;
                end
            end
            S_SCAN: begin
                n_ptr       = r_ptr + 21'd1;
                n_eval_vld  = 1'b1;
                n_eval_page = r_ptr;
                if (r_eval_vld) begin
                    if (r_eval_page >= r_end) begin
                        n_state    = S_IDLE;
                        n_done     = 1'b1;
                        n_status   = ST_NORUN;
                        n_eval_vld = 1'b0;
                    end else if (r_eval_page >= r_lim) begin
                        n_state    = S_IDLE;
                        n_done     = 1'b1;
                        n_status   = ST_INVALID;
                        n_eval_vld = 1'b0;
                    end else if (rd_data != PG_AVAIL) begin
                        n_run = '0;
                    end else begin
                        n_run = r_run + 13'd1;
                        if (r_run == '0) begin
                            n_run_base = r_eval_page[19:0];
                        end
                        if (r_run + 13'd1 >= r_count) begin
                            n_state    = S_WRITE;
                            n_eval_vld = 1'b0;
                            n_left     = r_count;
                            n_ptr      = (r_run == '0) ? r_eval_page : {1'b0, r_run_base};
                        end
                    end
                end
            end
            S_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = rd_off[IW-1:0];
                wr_data = PG_USED;
                n_ptr   = r_ptr + 21'd1;
                n_left  = r_left - 13'd1;
                if (r_left == 13'd1) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_base   = r_run_base;
                end
            end
            S_MODIFY: begin
                if (issue) begin
                    n_ptr = r_ptr + 21'd1;
                end
                n_eval_vld  = issue;
                n_eval_page = r_ptr;
                if (r_eval_vld) begin
                    if (r_action == ACT_FREE) begin
                        wr_en   = (rd_data == PG_USED);
                        wr_data = PG_AVAIL;
                    end else begin
                        wr_en   = (rd_data != PG_RESERVED);
                        wr_data = (r_action == ACT_MARK_USED) ? PG_USED : PG_RESERVED;
                    end
                    if (!issue) begin
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_base   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_idx     <= '0;
            r_clr_respond <= 1'b0;
            r_eval_vld    <= 1'b0;
            r_done        <= 1'b0;
            r_pool_base   <= '0;
        end else begin
            r_state       <= n_state;
            r_clr_idx     <= n_clr_idx;
            r_clr_respond <= n_clr_respond;
            r_eval_vld    <= n_eval_vld;
            r_done        <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pool_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_ptr       <= n_ptr;
        r_eval_page <= n_eval_page;
        r_end       <= n_end;
        r_stop      <= n_stop;
        r_lim       <= n_lim;
        r_count     <= n_count;
        r_run       <= n_run;
        r_run_base  <= n_run_base;
        r_left      <= n_left;
        r_status    <= n_status;
        r_base      <= n_base;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_base_page = r_base;

    `FFPRA_ASSERT_SAME(a_done_in_idle, r_done, r_state == S_IDLE, "result strobe outside idle")
    `FFPRA_ASSERT_NEXT(a_accept_moves, start && !busy, busy || r_done, "request taken but dropped")
    `FFPRA_ASSERT_SAME(a_fail_no_base, r_done && (r_status != ST_OK), r_base == '0, "base on failure")
    `FFPRA_ASSERT_SAME(a_write_left, r_state == S_WRITE, r_left != '0, "run write with no pages left")

endmodule

[tb/sv/page_alloc_checker.sv]
`timescale 1ns / 1ps

module page_alloc_checker
    import ffpra_pkg::*;
#(
    parameter int unsigned TABLE_PAGES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_action,
    input  logic [19:0] i_first_page,
    input  logic [20:0] i_end_page,
    input  logic [12:0] i_page_count,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [19:0] i_cfg_data,
    input  logic        i_done,
    input  logic [1:0]  i_status,
    input  logic [19:0] i_base_page,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] base_page;
    } t_page_answer;

    t_page_state  page_table [TABLE_PAGES];
    logic [19:0]  pool_base;
    t_page_answer expected_answers [$];
    int           mismatches;

    function automatic t_page_answer predict_page_request(input logic [2:0] act,
            input int unsigned first, input int unsigned last, input int unsigned count);
        t_page_answer ans;
        int unsigned  base;
        int unsigned  lim;
        int unsigned  p;
        int unsigned  run;
        int unsigned  run_base;
        ans.status    = ST_OK;
        ans.base_page = '0;
        base = pool_base;
        lim  = base + TABLE_PAGES;
        if (lim > PAGE_SPACE) begin
            lim = PAGE_SPACE;
        end
        if (act == ACT_CLEAR) begin
            foreach (page_table[i]) page_table[i] = PG_AVAIL;
        end else if (act > ACT_CLEAR || first < base) begin
            ans.status = ST_INVALID;
        end else if (act == ACT_ALLOC) begin
            if (count == 0) begin
                ans.status = ST_INVALID;
            end else begin
                run      = 0;
                run_base = 0;
                p        = first;
                while (p < last && run < count && ans.status == ST_OK) begin
                    if (p >= lim) begin
                        ans.status = ST_INVALID;
                    end else if (page_table[p - base] != PG_AVAIL) begin
                        run = 0;
                    end else begin
                        if (run == 0) begin
                            run_base = p;
                        end
                        run++;
                    end
                    p++;
                end
                if (ans.status == ST_OK) begin
                    if (run < count) begin
                        ans.status = ST_NORUN;
                    end else begin
                        for (p = run_base; p < run_base + run; p++) begin
                            page_table[p - base] = PG_USED;
                        end
                        ans.base_page = run_base[19:0];
                    end
                end
            end
        end else if (act == ACT_FREE) begin
            if (first + count > lim) begin
                ans.status = ST_INVALID;
            end else begin
                for (p = first; p < first + count; p++) begin
                    if (page_table[p - base] == PG_USED) begin
                        page_table[p - base] = PG_AVAIL;
                    end
                end
            end
        end else begin
            if (last > first && last > lim) begin
                ans.status = ST_INVALID;
            end else begin
                for (p = first; p < last; p++) begin
                    if (page_table[p - base] != PG_RESERVED) begin
                        page_table[p - base] = (act == ACT_MARK_USED) ? PG_USED : PG_RESERVED;
                    end
                end
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_page_answer head;
        if (!i_rst_n) begin
            foreach (page_table[i]) page_table[i] = PG_AVAIL;
            pool_base = '0;
            expected_answers.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                pool_base = i_cfg_data;
            end
            if (i_done === 1'b1) begin
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: status %0d base %05h", i_status,
                                 i_base_page);
                    end
                end else begin
                    head = expected_answers.pop_front();
                    if (head.status !== i_status || head.base_page !== i_base_page) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"mismatch: expected status %0d base %05h, ",
                                      "got status %0d base %05h"},
                                     head.status, head.base_page, i_status, i_base_page);
                        end
                    end
                end
            end
            if (start && !busy) begin
                expected_answers.push_back(predict_page_request(i_action, i_first_page,
                                                                i_end_page, i_page_count));
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_answers.size();
    end

endmodule

[tb/sv/first_fit_page_run_allocator_tb.sv]
`timescale 1ns / 1ps

module first_fit_page_run_allocator_tb;
    import ffpra_pkg::*;

    localparam int unsigned TABLE_PAGES     = 4096;
    localparam int          ITEMS_PER_PHASE = 190;
    localparam int          CYCLE_LIMIT     = 40000000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic [2:0]  i_action     = ACT_ALLOC;
    logic [19:0] i_first_page = '0;
    logic [20:0] i_end_page   = '0;
    logic [12:0] i_page_count = '0;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [19:0] i_cfg_data   = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [19:0] o_base_page;
    int          mismatches;
    int          pending;
    int          cycle_count  = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    first_fit_page_run_allocator #(
        .TABLE_PAGES(TABLE_PAGES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_first_page(i_first_page),
        .i_end_page  (i_end_page),
        .i_page_count(i_page_count),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_base_page (o_base_page)
    );

    page_alloc_checker #(
        .TABLE_PAGES(TABLE_PAGES)
    ) page_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_first_page(i_first_page),
        .i_end_page  (i_end_page),
        .i_page_count(i_page_count),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_done      (o_done),
        .i_status    (o_status),
        .i_base_page (o_base_page),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** first_fit_page_run_allocator: FAILED **");
        $finish;
    end

    task automatic send_request(input logic [2:0] act, input logic [19:0] first,
            input logic [20:0] last, input logic [12:0] count);
        i_action     <= act;
        i_first_page <= first;
        i_end_page   <= last;
        i_page_count <= count;
        start        <= 1'b1;
        do @(negedge i_clk); while (busy !== 1'b0);
        @(posedge i_clk);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_pool_base(input logic [19:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk); while (o_cfg_ready !== 1'b1);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Most requests stay in a small window at the bottom of the pool so that allocations,
    // frees and marks keep running into each other; the rest is out-of-pool and random noise.
    task automatic random_request(input int unsigned base);
        int unsigned lim;
        int unsigned win;
        int unsigned pick;
        int unsigned f;
        int unsigned e;
        int unsigned n;
        logic [2:0]  act;
        lim = base + TABLE_PAGES;
        if (lim > PAGE_SPACE) begin
            lim = PAGE_SPACE;
        end
        win  = (lim - base < 512) ? lim - base : 512;
        pick = $urandom_range(99);
        f    = base + $urandom_range(win - 1);
        e    = f + $urandom_range(64);
        n    = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        act  = ACT_ALLOC;
        if (pick < 36) begin
            act = ACT_ALLOC;
        end else if (pick < 60) begin
            act = ACT_FREE;
            n   = $urandom_range(32);
        end else if (pick < 74) begin
            act = ACT_MARK_USED;
            e   = f + $urandom_range(24);
        end else if (pick < 84) begin
            act = ACT_MARK_RESERVED;
            e   = f + $urandom_range(6);
        end else if (pick < 85) begin
            act = ACT_CLEAR;
        end else if (pick < 90) begin
            act = 3'($urandom_range(3));
            if (base == 0) begin
                f = $urandom_range(PAGE_SPACE - 1);
            end else begin
                f = base - $urandom_range(1, (base < 16) ? base : 16);
            end
            e = f + $urandom_range(64);
        end else begin
            act = 3'($urandom_range(7));
            f   = $urandom_range(PAGE_SPACE - 1);
            e   = $urandom_range(PAGE_SPACE);
            n   = $urandom_range(TABLE_PAGES);
        end
        if (e > PAGE_SPACE) begin
            e = PAGE_SPACE;
        end
        send_request(act, f[19:0], e[20:0], n[12:0]);
    endtask

    initial begin
        int unsigned bases [5];
        int          left;
        int          burst;
        bases[0] = $urandom_range(TABLE_PAGES, 1040000);
        bases[1] = PAGE_SPACE - 1;
        bases[2] = PAGE_SPACE - TABLE_PAGES;
        bases[3] = PAGE_SPACE - 2520;
        bases[4] = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(ACT_ALLOC, 20'd0, 21'd16, 13'd4);
        send_request(ACT_ALLOC, 20'd0, 21'd16, 13'd0);
        send_request(ACT_ALLOC, 20'd20, 21'd20, 13'd1);
        send_request(ACT_ALLOC, 20'd4090, 21'd1048576, 13'd16);
        send_request(ACT_FREE, 20'd4000, 21'd0, 13'd200);
        send_request(ACT_FREE, 20'd8, 21'd0, 13'd0);
        send_request(ACT_FREE, 20'd0, 21'd0, 13'd4);
        send_request(ACT_MARK_USED, 20'd10, 21'd20, 13'd0);
        send_request(ACT_MARK_RESERVED, 20'd15, 21'd30, 13'd0);
        pause(3);
        send_request(ACT_MARK_USED, 20'd5, 21'd40, 13'd0);
        send_request(ACT_ALLOC, 20'd0, 21'd64, 13'd8);
        send_request(ACT_FREE, 20'd0, 21'd0, 13'd4096);
        send_request(ACT_MARK_RESERVED, 20'hFFFFF, 21'd100, 13'd0);
        send_request(ACT_MARK_USED, 20'd4000, 21'd4097, 13'd0);
        send_request(ACT_ALLOC, 20'd0, 21'd4096, 13'd4096);
        for (int a = ACT_CLEAR + 1; a < 8; a++) begin
            send_request(a[2:0], 20'd0, 21'd16, 13'd1);
        end
        send_request(ACT_CLEAR, 20'd0, 21'd0, 13'd0);
        send_request(ACT_ALLOC, 20'd0, 21'd8, 13'd8);
        send_request(ACT_ALLOC, 20'd0, 21'd8, 13'd1);
        send_request(ACT_MARK_RESERVED, 20'd0, 21'd4096, 13'd0);
        send_request(ACT_ALLOC, 20'd0, 21'd1048576, 13'd1);
        send_request(ACT_CLEAR, 20'd0, 21'd0, 13'd0);
        drain();

        foreach (bases[ph]) begin
            write_pool_base(bases[ph][19:0]);
            left = ITEMS_PER_PHASE;
            while (left > 0) begin
                burst = ($urandom_range(7) == 0) ? 40 : $urandom_range(1, 12);
                while (burst > 0 && left > 0) begin
                    random_request(bases[ph]);
                    burst--;
                    left--;
                end
                pause($urandom_range(1, 20));
            end
            drain();
        end

        repeat (64) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("** first_fit_page_run_allocator: PASSED **");
        end else begin
            $display("** first_fit_page_run_allocator: FAILED **");
        end
        $finish;
    end

endmodule
